@@ src/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// CIGAR position remap package
// Shared types, operator and status codes, and the operator decoder.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_CHAR  = 1'b1;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_M    = 3'd1;
	localparam logic [2:0] OP_X    = 3'd2;
	localparam logic [2:0] OP_EQ   = 3'd3;
	localparam logic [2:0] OP_N    = 3'd4;
	localparam logic [2:0] OP_D    = 3'd5;
	localparam logic [2:0] OP_I    = 3'd6;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_POS      = 3'd1;
	localparam logic [2:0] ST_NO_NUM   = 3'd2;
	localparam logic [2:0] ST_BAD_OP   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;
	localparam logic [2:0] ST_ENDED    = 3'd5;
	localparam logic [2:0] ST_FINAL_OP = 3'd6;

	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_X    = 8'h58;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef struct packed {
		logic        req_type;
		logic [31:0] query_pos;
		logic [31:0] seq_len;
		logic [7:0]  char_code;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [31:0] alt_count;
		logic [31:0] ref_count;
		logic [31:0] run_length;
		logic        have_digits;
		logic [2:0]  last_op_code;
		logic        walk_frozen;
		logic [2:0]  error_code;
		logic [31:0] target_pos;
		logic [31:0] target_len;
	} walk_t;

	function automatic logic [2:0] op_of(input logic [7:0] c);
		logic [2:0] op;
		unique case (c)
			CH_M:    op = OP_M;
			CH_X:    op = OP_X;
			CH_EQ:   op = OP_EQ;
			CH_N:    op = OP_N;
			CH_D:    op = OP_D;
			CH_I:    op = OP_I;
			default: op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

@@ src/cpr_walk.sv @@
// ----------------------------------------------------------------------------
// CIGAR walk state
// Holds the walk registers and applies one start or character word to them.
// ----------------------------------------------------------------------------
module cpr_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cpr_pkg::item_t      item,
	input  logic [2:0]          fin_status,
	output cpr_pkg::walk_t      nxt
);

	cpr_pkg::walk_t walk_q;
	cpr_pkg::walk_t wr;
	logic [35:0]    ten_x;
	logic [2:0]     op;
	logic [31:0]    alt_new;

	always_comb begin
		ten_x   = ({4'b0, walk_q.run_length} << 3) + ({4'b0, walk_q.run_length} << 1)
			+ {32'b0, item.char_code[3:0]};
		op      = cpr_pkg::op_of(item.char_code);
		alt_new = walk_q.alt_count;
		nxt     = walk_q;
		if (item.req_type == cpr_pkg::REQ_START) begin
			nxt.alt_count    = '0;
			nxt.ref_count    = '0;
			nxt.run_length   = '0;
			nxt.have_digits  = 1'b0;
			nxt.last_op_code = cpr_pkg::OP_NONE;
			nxt.walk_frozen  = 1'b0;
			nxt.error_code   = cpr_pkg::ST_OK;
			nxt.target_pos   = item.query_pos;
			nxt.target_len   = item.seq_len;
		end else if (!walk_q.walk_frozen && walk_q.error_code == cpr_pkg::ST_OK) begin
			if (item.char_code >= cpr_pkg::CH_ZERO && item.char_code <= cpr_pkg::CH_NINE) begin
				nxt.run_length  = (ten_x[35:32] != 4'd0) ? 32'hFFFF_FFFF : ten_x[31:0];
				nxt.have_digits = 1'b1;
			end else if (!walk_q.have_digits) begin
				nxt.error_code = cpr_pkg::ST_NO_NUM;
			end else if (op == cpr_pkg::OP_NONE) begin
				nxt.error_code = cpr_pkg::ST_BAD_OP;
			end else begin
				if (op != cpr_pkg::OP_I) begin
					nxt.ref_count = walk_q.ref_count + walk_q.run_length;
				end
				if (op != cpr_pkg::OP_N && op != cpr_pkg::OP_D) begin
					alt_new = walk_q.alt_count + walk_q.run_length;
				end
				nxt.alt_count    = alt_new;
				nxt.last_op_code = op;
				nxt.run_length   = '0;
				nxt.have_digits  = 1'b0;
				nxt.walk_frozen  = alt_new > walk_q.target_pos;
			end
		end
	end

	always_comb begin
		wr = nxt;
		if (item.last) begin
			wr.have_digits = 1'b0;
			wr.run_length  = '0;
			wr.walk_frozen = 1'b1;
			if (fin_status != cpr_pkg::ST_OK && fin_status != cpr_pkg::ST_POS) begin
				wr.error_code = fin_status;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (en) begin
			walk_q <= wr;
		end
	end

endmodule

@@ src/cpr_result.sv @@
// ----------------------------------------------------------------------------
// CIGAR result stage
// Forms the offset and status at the end of a string and holds the result word.
// ----------------------------------------------------------------------------
module cpr_result (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  cpr_pkg::walk_t w,
	output logic [2:0]     status,
	input  logic           m_tready,
	output logic           m_tvalid,
	output logic [39:0]    m_tdata
);

	logic [31:0] offset;
	logic        valid_q;
	logic [31:0] offset_q;
	logic [2:0]  status_q;

	always_comb begin
		status = cpr_pkg::ST_OK;
		offset = '0;
		if (w.target_pos >= w.target_len) begin
			status = cpr_pkg::ST_POS;
		end else if (w.error_code != cpr_pkg::ST_OK) begin
			status = w.error_code;
		end else if (!w.walk_frozen && w.have_digits) begin
			status = cpr_pkg::ST_BAD_OP;
		end else if (w.alt_count > w.target_len) begin
			status = cpr_pkg::ST_TOO_LONG;
		end else if (w.alt_count == w.target_pos) begin
			offset = w.ref_count;
		end else if (w.alt_count > w.target_pos) begin
			case (w.last_op_code) inside
				cpr_pkg::OP_M, cpr_pkg::OP_X, cpr_pkg::OP_EQ: begin
					offset = w.ref_count - (w.alt_count - w.target_pos);
				end
				cpr_pkg::OP_I: begin
					offset = w.ref_count;
				end
				default: begin
					status = cpr_pkg::ST_FINAL_OP;
				end
			endcase
		end else begin
			status = cpr_pkg::ST_ENDED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			offset_q <= offset;
			status_q <= status;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'b0, status_q, offset_q};

endmodule

@@ src/cigar_position_remap_core.sv @@
// ----------------------------------------------------------------------------
// CIGAR position remap core
// Maps a query position to a reference offset by walking CIGAR text.
// ----------------------------------------------------------------------------
// The slave stream takes one word per cycle while s_tready is high. A start
// word (tuser = 0) loads the query position and sequence length; a character
// word (tuser = 1) brings one CIGAR character. A word with tlast set ends the
// string and produces one result word on the master stream; other words
// produce none. Every accepted word is held in the input register, where the
// walk update and the end-of-string checks are done, and a result is held in
// the output register. A result thus reaches the master side through the input
// register and then the output register, and the core takes one word per
// cycle when the master side keeps up.
// When the receiver stalls with a result pending, the core keeps taking words
// that produce no result; a word with tlast waits in the input register, with
// tready held low, until the output register frees up.
// Reset clears the walk state and both valid flags; no output is pending.
// ----------------------------------------------------------------------------
module cigar_position_remap_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // query_pos, seq_len, char_code
	input  logic [0:0]  s_tuser,  // req_type
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // ref_offset, status, zero fill
);

	logic           valid_s1;
	cpr_pkg::item_t item_s1;
	logic           adv;
	cpr_pkg::walk_t nxt;
	logic [2:0]     status;

	assign adv      = valid_s1 && (!item_s1.last || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type  <= s_tuser[0];
			item_s1.query_pos <= s_tdata[31:0];
			item_s1.seq_len   <= s_tdata[63:32];
			item_s1.char_code <= s_tdata[71:64];
			item_s1.last      <= s_tlast;
		end
	end

	cpr_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.item       (item_s1),
		.fin_status (status),
		.nxt        (nxt)
	);

	cpr_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && item_s1.last),
		.w        (nxt),
		.status   (status),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

@@ sim/cigar_position_remap_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR position remap core testbench
// A short directed set of strings covers the corner cases of the walk. Random
// CIGAR strings follow, mostly well formed and some of them corrupted. A
// scoreboard predicts the mapped offset and status of every string end and
// compares each result word against it. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module cigar_position_remap_core_tb;

	class remap_scoreboard;
		typedef struct {
			bit [31:0] offset;
			bit [2:0]  status;
		} remap_result_t;

		bit [31:0] alt_count, ref_count, run_len, target_pos, target_len;
		bit        have_digits, frozen;
		bit [2:0]  last_op, err;
		remap_result_t pending_results[$];
		int errors;

		function void note_word(bit req, bit [31:0] qpos, bit [31:0] slen, bit [7:0] ch,
			bit last);
			bit [63:0]     v;
			bit [2:0]      op;
			remap_result_t res;
			if (req == cpr_pkg::REQ_START) begin
				alt_count   = '0;
				ref_count   = '0;
				run_len     = '0;
				have_digits = 1'b0;
				last_op     = cpr_pkg::OP_NONE;
				frozen      = 1'b0;
				err         = cpr_pkg::ST_OK;
				target_pos  = qpos;
				target_len  = slen;
			end else if (!frozen && err == cpr_pkg::ST_OK) begin
				if (ch >= cpr_pkg::CH_ZERO && ch <= cpr_pkg::CH_NINE) begin
					v = 64'(run_len) * 64'd10 + 64'(ch - cpr_pkg::CH_ZERO);
					run_len = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
					have_digits = 1'b1;
				end else if (!have_digits) begin
					err = cpr_pkg::ST_NO_NUM;
				end else begin
					case (ch)
						cpr_pkg::CH_M:  op = cpr_pkg::OP_M;
						cpr_pkg::CH_X:  op = cpr_pkg::OP_X;
						cpr_pkg::CH_EQ: op = cpr_pkg::OP_EQ;
						cpr_pkg::CH_N:  op = cpr_pkg::OP_N;
						cpr_pkg::CH_D:  op = cpr_pkg::OP_D;
						cpr_pkg::CH_I:  op = cpr_pkg::OP_I;
						default:        op = cpr_pkg::OP_NONE;
					endcase
					if (op == cpr_pkg::OP_NONE) begin
						err = cpr_pkg::ST_BAD_OP;
					end else begin
						if (op != cpr_pkg::OP_I)
							ref_count += run_len;
						if (op != cpr_pkg::OP_N && op != cpr_pkg::OP_D)
							alt_count += run_len;
						last_op     = op;
						run_len     = '0;
						have_digits = 1'b0;
						if (alt_count > target_pos)
							frozen = 1'b1;
					end
				end
			end
			if (!last)
				return;
			res.offset = '0;
			res.status = cpr_pkg::ST_OK;
			if (target_pos >= target_len) begin
				res.status = cpr_pkg::ST_POS;
			end else if (err != cpr_pkg::ST_OK) begin
				res.status = err;
			end else if (!frozen && have_digits) begin
				res.status = cpr_pkg::ST_BAD_OP;
			end else if (alt_count > target_len) begin
				res.status = cpr_pkg::ST_TOO_LONG;
			end else if (alt_count == target_pos) begin
				res.offset = ref_count;
			end else if (alt_count > target_pos) begin
				if (last_op == cpr_pkg::OP_M || last_op == cpr_pkg::OP_X
					|| last_op == cpr_pkg::OP_EQ)
					res.offset = ref_count - (alt_count - target_pos);
				else if (last_op == cpr_pkg::OP_I)
					res.offset = ref_count;
				else
					res.status = cpr_pkg::ST_FINAL_OP;
			end else begin
				res.status = cpr_pkg::ST_ENDED;
			end
			if (res.status != cpr_pkg::ST_OK) begin
				res.offset = '0;
				if (res.status != cpr_pkg::ST_POS)
					err = res.status;
			end
			have_digits = 1'b0;
			run_len     = '0;
			frozen      = 1'b1;
			pending_results.push_back(res);
		endfunction

		function void check_word(bit [39:0] word);
			remap_result_t res;
			if (pending_results.size() == 0) begin
				$display("%0t: result word with none expected, got %h", $time, word);
				errors++;
				return;
			end
			res = pending_results.pop_front();
			if (word[31:0] != res.offset) begin
				$display("%0t: ref_offset mismatch, expected %h, got %h", $time, res.offset,
					word[31:0]);
				errors++;
			end
			if (word[34:32] != res.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time, res.status,
					word[34:32]);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	remap_scoreboard sb = new;
	bit              gaps_on = 1'b1;
	int              words_sent;
	bit [7:0]        op_chars [6] = '{cpr_pkg::CH_M, cpr_pkg::CH_X, cpr_pkg::CH_EQ,
		cpr_pkg::CH_N, cpr_pkg::CH_D, cpr_pkg::CH_I};

	cigar_position_remap_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_word(s_tuser[0], s_tdata[31:0], s_tdata[63:32], s_tdata[71:64], s_tlast);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata);
		end
	end

	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	task automatic send_word(input bit req, input bit [31:0] qpos, input bit [31:0] slen,
		input bit [7:0] ch, input bit last);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {ch, slen, qpos};
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
	endtask

	task automatic send_start(input bit [31:0] qpos, input bit [31:0] slen, input bit last);
		send_word(cpr_pkg::REQ_START, qpos, slen, 8'($urandom), last);
	endtask

	task automatic send_char(input bit [7:0] ch, input bit last);
		send_word(cpr_pkg::REQ_CHAR, $urandom, $urandom, ch, last);
	endtask

	task automatic run_cigar_query();
		byte unsigned    text[$];
		string           digits;
		longint unsigned alt_sum, count;
		bit [7:0]        op_char;
		bit [31:0]       qpos, slen;
		int              nops, r;
		alt_sum = 0;
		nops = $urandom_range(1, 6);
		for (int k = 0; k < nops; k++) begin
			op_char = op_chars[$urandom_range(0, 5)];
			r = $urandom_range(0, 99);
			if (r < 65)
				count = $urandom_range(0, 20);
			else if (r < 93)
				count = $urandom_range(21, 3000);
			else if (r < 97)
				count = $urandom;
			else
				count = 64'd99999999999;
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(1, 3)) text.push_back(cpr_pkg::CH_ZERO);
			digits = $sformatf("%0d", count);
			foreach (digits[i])
				text.push_back(digits[i]);
			text.push_back(op_char);
			if (op_char != cpr_pkg::CH_N && op_char != cpr_pkg::CH_D)
				alt_sum += (count > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : count;
		end

		// A minority of strings is broken on purpose.
		r = $urandom_range(0, 99);
		if (r < 4)
			text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
		else if (r < 7)
			text.push_back(cpr_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		else if (r < 10)
			text.delete($urandom_range(0, text.size() - 1));
		else if (r < 12)
			text.push_front(op_chars[$urandom_range(0, 5)]);
		else if (r < 14)
			text.delete();

		r = $urandom_range(0, 99);
		if (alt_sum > 64'hFFFF_FFF0 || r >= 90) begin
			qpos = $urandom;
			slen = $urandom;
		end else if (r < 55) begin
			slen = 32'(alt_sum);
			qpos = $urandom_range(0, 32'(alt_sum));
		end else if (r < 70) begin
			slen = 32'(alt_sum) + $urandom_range(1, 9);
			qpos = $urandom_range(0, slen - 1);
		end else if (r < 80) begin
			slen = (alt_sum > 3) ? 32'(alt_sum) - 3 : 32'd0;
			qpos = $urandom_range(0, 32'(alt_sum));
		end else begin
			slen = $urandom_range(0, 32'(alt_sum));
			qpos = slen + $urandom_range(0, 3);
		end

		if ($urandom_range(0, 49) != 0)
			send_start(qpos, slen, text.size() == 0);
		foreach (text[i])
			send_char(text[i], i == text.size() - 1);
		if ($urandom_range(0, 19) == 0)
			send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Characters before any start word act on the reset state.
		send_char(cpr_pkg::CH_ZERO + 8'd7, 1'b0);
		send_char(cpr_pkg::CH_EQ, 1'b1);
		send_start(32'd3, 32'd10, 1'b0);
		send_char(cpr_pkg::CH_ZERO + 8'd1, 1'b0);
		send_char(cpr_pkg::CH_ZERO, 1'b0);
		send_char(cpr_pkg::CH_M, 1'b1);
		// An empty string, then a repeated end without a new start.
		send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_char(cpr_pkg::CH_X, 1'b1);
		send_start(32'd1, 32'd5, 1'b0);
		send_char(8'h00, 1'b1);
		send_start(32'd1, 32'd5, 1'b0);
		send_char(cpr_pkg::CH_ZERO + 8'd2, 1'b0);
		send_char(8'hFF, 1'b1);
		send_start(32'd1, 32'd5, 1'b0);
		send_char(cpr_pkg::CH_ZERO + 8'd2, 1'b0);
		send_char(cpr_pkg::CH_D, 1'b0);
		send_char(cpr_pkg::CH_ZERO + 8'd4, 1'b1);
		send_start(32'd2, 32'd3, 1'b0);
		send_char(cpr_pkg::CH_ZERO + 8'd5, 1'b0);
		send_char(cpr_pkg::CH_X, 1'b1);
		send_start(32'd2, 32'd9, 1'b0);
		send_char(cpr_pkg::CH_ZERO + 8'd1, 1'b0);
		send_char(cpr_pkg::CH_N, 1'b1);
		send_start(32'd0, 32'd2, 1'b0);
		send_char(cpr_pkg::CH_ZERO + 8'd1, 1'b0);
		send_char(cpr_pkg::CH_I, 1'b1);

		while (words_sent < 1450) begin
			if ($urandom_range(0, 9) == 0)
				gaps_on = !gaps_on;
			run_cigar_query();
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ cigar_position_remap_core.f @@
src/cpr_pkg.sv
src/cpr_walk.sv
src/cpr_result.sv
src/cigar_position_remap_core.sv
sim/cigar_position_remap_core_tb.sv
